[design/isb_pkg.sv]
// shared types, codes and defaults for the interlaced 2bpp shadow blitter
package isb_pkg;

	localparam int SCREEN_WIDTH_DEF    = 320;
	localparam int SCREEN_HEIGHT_DEF   = 200;
	localparam int ODD_BANK_OFFSET_DEF = 8192;

	localparam int FB_W  = 14;
	localparam int CMP_W = 11;

	localparam logic [1:0] ACT_PIXEL = 2'd0;
	localparam logic [1:0] ACT_BLOCK = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	localparam logic [7:0] COLOR_MAX = 8'd16;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACCESS
	} state_t;

	typedef struct packed {
		logic [1:0] action;
		logic [8:0] x;
		logic [7:0] y;
		logic [7:0] color;
		logic [9:0] right_col;
		logic [9:0] bottom_row;
	} req_t;

	typedef struct packed {
		logic [FB_W-1:0] fb_address;
		logic [7:0]      fb_data;
		logic            last;
	} rsp_t;

endpackage

[design/interlaced_2bpp_shadow_blitter_top.sv]
// shadow store with pixel read-modify-write and interlaced block copy out
//
//  channel  | direction | handshake            | payload
//  req      | in        | req_valid/req_ready  | isb_pkg::req_t
//  rsp      | out       | rsp_valid/rsp_ready  | isb_pkg::rsp_t
//
// block start, idle tick, unused action and off-screen pixel: handled in ST_IDLE
// put pixel and copy tick: go through ST_ACCESS, after the store's registered read
// after reset the store is zeroed, one byte a cycle, all ROW_BYTES*SCREEN_HEIGHT
// bytes (16000 at default size), with req_ready low
// a tick holds in ST_ACCESS while a previous item waits on rsp
module interlaced_2bpp_shadow_blitter_top #(
	parameter int SCREEN_WIDTH    = isb_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT   = isb_pkg::SCREEN_HEIGHT_DEF,
	parameter int ODD_BANK_OFFSET = isb_pkg::ODD_BANK_OFFSET_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  isb_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output isb_pkg::rsp_t  rsp
);

	localparam int ROW_BYTES   = (SCREEN_WIDTH + 3) / 4;
	localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int COL_W       = $clog2(SCREEN_WIDTH);
	localparam int ROW_W       = $clog2(SCREEN_HEIGHT);
	localparam int BCOL_W      = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
	localparam int FB_W        = isb_pkg::FB_W;
	localparam int CMP_W       = isb_pkg::CMP_W;

	localparam logic [CMP_W-1:0]  WIDTH_C    = CMP_W'(SCREEN_WIDTH);
	localparam logic [CMP_W-1:0]  HEIGHT_C   = CMP_W'(SCREEN_HEIGHT);
	localparam logic [ADDR_W-1:0] ROWB_A     = ADDR_W'(ROW_BYTES);
	localparam logic [ADDR_W-1:0] CLR_END    = ADDR_W'(STORE_BYTES - 1);
	localparam logic [FB_W-1:0]   ROWB_F     = FB_W'(ROW_BYTES);
	localparam logic [FB_W-1:0]   ODD_OFF    = FB_W'(ODD_BANK_OFFSET);

	isb_pkg::state_t state_q, state_nx;

	logic [7:0] mem [STORE_BYTES];
	logic [7:0] rd_data_q;

	logic [ADDR_W-1:0] clr_q;

	logic              busy_q;
	logic              odd_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [ROW_W-1:0]  start_row_q;
	logic [ROW_W-1:0]  end_row_q;
	logic [BCOL_W-1:0] cur_col_q;
	logic [BCOL_W-1:0] first_col_q;
	logic [BCOL_W-1:0] end_col_q;

	logic              is_pix_q;
	logic [1:0]        pix_sel_q;
	logic [1:0]        pix_c_q;
	logic [ADDR_W-1:0] addr_q;
	logic [FB_W-1:0]   pend_fb_q;
	logic              pend_last_q;

	logic          rsp_valid_q;
	isb_pkg::rsp_t rsp_q;

	logic              acc;
	logic [CMP_W-1:0]  x_w, y_w, rc_w, br_w;
	logic [COL_W-1:0]  x1c, x2c;
	logic [ROW_W-1:0]  y1c, y2c;
	logic              pix_ok;
	logic              tick_go;
	logic              need_access;
	logic [ADDR_W-1:0] pix_idx;
	logic [ADDR_W-1:0] tick_idx;
	logic [ADDR_W-1:0] rd_addr;
	logic [1:0]        pix_c;
	logic [FB_W-1:0]   tick_fb;
	logic [ROW_W:0]    row_plus2;
	logic              busy_nx;
	logic              odd_nx;
	logic [ROW_W-1:0]  row_nx;
	logic [BCOL_W-1:0] col_nx;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [7:0]        mem_wd;
	logic [7:0]        merged;
	logic              access_done;
	logic              rsp_load;

	assign acc  = req_valid & req_ready;
	assign x_w  = CMP_W'(req.x);
	assign y_w  = CMP_W'(req.y);
	assign rc_w = CMP_W'(req.right_col);
	assign br_w = CMP_W'(req.bottom_row);

	// clamp block corners to the screen, top row rounded down to even
	always_comb begin
		x1c = (x_w  >= WIDTH_C)  ? COL_W'(WIDTH_C - 1'b1)  : COL_W'(x_w);
		x2c = (rc_w >= WIDTH_C)  ? COL_W'(WIDTH_C - 1'b1)  : COL_W'(rc_w);
		y1c = (y_w  >= HEIGHT_C) ? ROW_W'(HEIGHT_C - 1'b1) : ROW_W'(y_w);
		y2c = (br_w >= HEIGHT_C) ? ROW_W'(HEIGHT_C - 1'b1) : ROW_W'(br_w);
		y1c[0] = 1'b0;
	end

	assign pix_ok  = (x_w < WIDTH_C) && (y_w < HEIGHT_C);
	assign pix_idx = ADDR_W'(ADDR_W'(req.y) * ROWB_A) + ADDR_W'(req.x >> 2);
	assign pix_c   = (req.color > isb_pkg::COLOR_MAX) ? 2'b00 : req.color[1:0];
	assign tick_go = (req.action == isb_pkg::ACT_TICK) && busy_q;

	assign need_access = acc && (((req.action == isb_pkg::ACT_PIXEL) && pix_ok) || tick_go);

	assign tick_idx = ADDR_W'(ADDR_W'(cur_row_q) * ROWB_A) + ADDR_W'(cur_col_q);
	assign tick_fb  = FB_W'(ROWB_F * FB_W'(cur_row_q >> 1)) + FB_W'(cur_col_q)
		+ (odd_q ? ODD_OFF : '0);
	assign rd_addr  = (req.action == isb_pkg::ACT_PIXEL) ? pix_idx : tick_idx;

	// copy walk: byte columns, then even rows, then odd rows
	always_comb begin
		busy_nx   = busy_q;
		odd_nx    = odd_q;
		row_nx    = cur_row_q;
		col_nx    = cur_col_q;
		row_plus2 = {1'b0, cur_row_q} + (ROW_W+1)'(2);
		if (cur_col_q < end_col_q) begin
			col_nx = cur_col_q + 1'b1;
		end else begin
			col_nx = first_col_q;
			if (row_plus2 > {1'b0, end_row_q}) begin
				if (!odd_q && ({1'b0, start_row_q} + 1'b1 <= {1'b0, end_row_q})) begin
					odd_nx = 1'b1;
					row_nx = start_row_q + 1'b1;
				end else begin
					busy_nx = 1'b0;
				end
			end else begin
				row_nx = ROW_W'(row_plus2);
			end
		end
	end

	always_comb begin
		merged = rd_data_q;
		merged[{~pix_sel_q, 1'b0} +: 2] = pix_c_q;
	end

	always_comb begin
		req_ready   = 1'b0;
		mem_we      = 1'b0;
		mem_wa      = addr_q;
		mem_wd      = merged;
		access_done = 1'b0;
		rsp_load    = 1'b0;
		case (state_q)
			isb_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
			end
			isb_pkg::ST_IDLE: begin
				req_ready = 1'b1;
			end
			isb_pkg::ST_ACCESS: begin
				if (is_pix_q) begin
					mem_we      = 1'b1;
					access_done = 1'b1;
				end else if (!rsp_valid_q || rsp_ready) begin
					rsp_load    = 1'b1;
					access_done = 1'b1;
				end
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			isb_pkg::ST_CLEAR: begin
				if (clr_q == CLR_END) state_nx = isb_pkg::ST_IDLE;
			end
			isb_pkg::ST_IDLE: begin
				if (need_access) state_nx = isb_pkg::ST_ACCESS;
			end
			isb_pkg::ST_ACCESS: begin
				if (access_done) state_nx = isb_pkg::ST_IDLE;
			end
			default: begin
				state_nx = isb_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
	end

	always_ff @(posedge clk) begin
		if (need_access) rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= isb_pkg::ST_CLEAR;
			clr_q       <= '0;
			busy_q      <= 1'b0;
			odd_q       <= 1'b0;
			cur_row_q   <= '0;
			start_row_q <= '0;
			end_row_q   <= '0;
			cur_col_q   <= '0;
			first_col_q <= '0;
			end_col_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == isb_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (acc && (req.action == isb_pkg::ACT_BLOCK)) begin
				odd_q <= 1'b0;
				if ((x2c < x1c) || (y2c < y1c)) begin
					busy_q <= 1'b0;
				end else begin
					busy_q      <= 1'b1;
					first_col_q <= BCOL_W'(x1c >> 2);
					cur_col_q   <= BCOL_W'(x1c >> 2);
					end_col_q   <= BCOL_W'(x2c >> 2);
					start_row_q <= y1c;
					cur_row_q   <= y1c;
					end_row_q   <= y2c;
				end
			end else if (acc && tick_go) begin
				busy_q    <= busy_nx;
				odd_q     <= odd_nx;
				cur_row_q <= row_nx;
				cur_col_q <= col_nx;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (need_access) begin
			is_pix_q    <= (req.action == isb_pkg::ACT_PIXEL);
			pix_sel_q   <= req.x[1:0];
			pix_c_q     <= pix_c;
			addr_q      <= pix_idx;
			pend_fb_q   <= tick_fb;
			pend_last_q <= !busy_nx;
		end
		if (rsp_load) begin
			rsp_q.fb_address <= pend_fb_q;
			rsp_q.fb_data    <= rd_data_q;
			rsp_q.last       <= pend_last_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[tb/blit_checker.sv]
// framebuffer write predictor and checker for the interlaced 2bpp shadow blitter
module blit_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  isb_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  isb_pkg::rsp_t rsp,
	output int            mismatches,
	output int            pending,
	output int            pixels_drawn,
	output int            copies_armed,
	output int            writes_seen
);

	localparam int SCREEN_W = isb_pkg::SCREEN_WIDTH_DEF;
	localparam int SCREEN_H = isb_pkg::SCREEN_HEIGHT_DEF;
	localparam int ODD_OFS  = isb_pkg::ODD_BANK_OFFSET_DEF;
	localparam int ROW_B    = (SCREEN_W + 3) / 4;
	localparam int STORE_B  = ROW_B * SCREEN_H;

	logic [7:0]    shadow_bytes [0:STORE_B-1];
	isb_pkg::rsp_t expected_writes [$];

	logic copy_active;
	logic odd_bank_pass;
	int   row_now;
	int   col_now;
	int   col_first;
	int   col_last;
	int   row_top;
	int   row_bottom;
	int   fail_count;
	int   pixel_count;
	int   copy_count;
	int   write_count;

	function automatic int clamp_dim(int v, int lim);
		return (v >= lim) ? lim - 1 : v;
	endfunction

	task automatic draw_pixel(isb_pkg::req_t pkt);
		int         idx;
		int         sh;
		logic [7:0] cb;
		logic [7:0] mask;
		if (pkt.x >= SCREEN_W || pkt.y >= SCREEN_H) begin
			return;
		end
		idx = int'(pkt.y) * ROW_B + int'(pkt.x) / 4;
		cb = (pkt.color > isb_pkg::COLOR_MAX) ? 8'h00 : {6'b0, pkt.color[1:0]};
		sh = 2 * int'(pkt.x[1:0]);
		mask = 8'hc0 >> sh;
		shadow_bytes[idx] = (shadow_bytes[idx] & ~mask) | (cb << (6 - sh));
		pixel_count++;
	endtask

	task automatic arm_copy(isb_pkg::req_t pkt);
		int x1;
		int y1;
		int x2;
		int y2;
		x1 = clamp_dim(pkt.x, SCREEN_W);
		y1 = clamp_dim(pkt.y, SCREEN_H) & ~1;
		x2 = clamp_dim(pkt.right_col, SCREEN_W);
		y2 = clamp_dim(pkt.bottom_row, SCREEN_H);
		copy_active = 1'b0;
		odd_bank_pass = 1'b0;
		if (x2 < x1 || y2 < y1) begin
			return;
		end
		col_first = x1 / 4;
		col_last = x2 / 4;
		row_top = y1;
		row_bottom = y2;
		row_now = y1;
		col_now = col_first;
		copy_active = 1'b1;
		copy_count++;
	endtask

	task automatic next_write();
		int            addr;
		isb_pkg::rsp_t want;
		if (!copy_active) begin
			return;
		end
		addr = ROW_B * (row_now / 2) + col_now + (odd_bank_pass ? ODD_OFS : 0);
		want.fb_address = addr[isb_pkg::FB_W-1:0];
		want.fb_data = shadow_bytes[row_now * ROW_B + col_now];
		if (col_now < col_last) begin
			col_now++;
		end else begin
			col_now = col_first;
			row_now += 2;
			if (row_now > row_bottom) begin
				if (!odd_bank_pass && row_top + 1 <= row_bottom) begin
					odd_bank_pass = 1'b1;
					row_now = row_top + 1;
				end else begin
					copy_active = 1'b0;
				end
			end
		end
		want.last = !copy_active;
		expected_writes.push_back(want);
	endtask

	task automatic check_write(isb_pkg::rsp_t got);
		isb_pkg::rsp_t want;
		write_count++;
		if (expected_writes.size() == 0) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("unexpected fb write: addr %0d data %02h last %0b",
					got.fb_address, got.fb_data, got.last);
			end
			return;
		end
		want = expected_writes.pop_front();
		if (got.fb_address !== want.fb_address || got.fb_data !== want.fb_data ||
				got.last !== want.last) begin
			fail_count++;
			if (fail_count <= 10) begin
				$write("fb write mismatch: expected addr %0d data %02h last %0b, ",
					want.fb_address, want.fb_data, want.last);
				$display("got addr %0d data %02h last %0b",
					got.fb_address, got.fb_data, got.last);
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			foreach (shadow_bytes[i]) shadow_bytes[i] = 8'h00;
			expected_writes.delete();
			copy_active = 1'b0;
			odd_bank_pass = 1'b0;
			row_now = 0;
			col_now = 0;
			col_first = 0;
			col_last = 0;
			row_top = 0;
			row_bottom = 0;
			fail_count = 0;
			pixel_count = 0;
			copy_count = 0;
			write_count = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				check_write(rsp);
			end
			if (req_valid && req_ready) begin
				case (req.action)
					isb_pkg::ACT_PIXEL: draw_pixel(req);
					isb_pkg::ACT_BLOCK: arm_copy(req);
					isb_pkg::ACT_TICK:  next_write();
					default:   ;
				endcase
			end
		end
		mismatches <= fail_count;
		pending <= expected_writes.size();
		pixels_drawn <= pixel_count;
		copies_armed <= copy_count;
		writes_seen <= write_count;
	end

endmodule

[tb/tb.sv]
// top of the blitter testbench: clock, reset, item stimulus, result sink and verdict
module tb;

	localparam logic [1:0] ACT_UNUSED   = 2'd3;
	localparam int         ITEM_TARGET  = 1450;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         IDLE_LIMIT   = 60000;
	localparam int         TAIL_CYCLES  = 20;
	localparam int         SCREEN_W     = isb_pkg::SCREEN_WIDTH_DEF;
	localparam int         SCREEN_H     = isb_pkg::SCREEN_HEIGHT_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	isb_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	isb_pkg::rsp_t rsp;

	int   mismatches;
	int   pending;
	int   pixels_drawn;
	int   copies_armed;
	int   writes_seen;
	int   items_sent = 0;
	int   idle_cycles = 0;
	logic req_burst = 1'b0;
	logic rsp_burst = 1'b0;
	logic hold_rsp = 1'b0;

	always #2 clk = ~clk;

	interlaced_2bpp_shadow_blitter_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	blit_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp          (rsp),
		.mismatches   (mismatches),
		.pending      (pending),
		.pixels_drawn (pixels_drawn),
		.copies_armed (copies_armed),
		.writes_seen  (writes_seen)
	);

	function automatic isb_pkg::req_t mk(logic [1:0] a, int x, int y, int c, int rc, int br);
		isb_pkg::req_t pkt;
		pkt.action = a;
		pkt.x = x[8:0];
		pkt.y = y[7:0];
		pkt.color = c[7:0];
		pkt.right_col = rc[9:0];
		pkt.bottom_row = br[9:0];
		return pkt;
	endfunction

	function automatic isb_pkg::req_t random_fields(logic [1:0] a);
		return mk(a, $urandom_range(0, 511), $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 1023), $urandom_range(0, 1023));
	endfunction

	function automatic isb_pkg::req_t rect_pixel(int x1, int w, int y1, int h);
		int c;
		c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 16);
		return mk(isb_pkg::ACT_PIXEL, x1 + $urandom_range(0, w),
			y1 + $urandom_range(0, h), c,
			$urandom_range(0, 1023), $urandom_range(0, 1023));
	endfunction

	// number of writes a block start arms
	function automatic int copy_len(isb_pkg::req_t pkt);
		int x1;
		int y1;
		int x2;
		int y2;
		x1 = (pkt.x >= SCREEN_W) ? SCREEN_W - 1 : int'(pkt.x);
		y1 = ((pkt.y >= SCREEN_H) ? SCREEN_H - 1 : int'(pkt.y)) & ~1;
		x2 = (pkt.right_col >= SCREEN_W) ? SCREEN_W - 1 : int'(pkt.right_col);
		y2 = (pkt.bottom_row >= SCREEN_H) ? SCREEN_H - 1 : int'(pkt.bottom_row);
		if (x2 < x1 || y2 < y1) begin
			return 0;
		end
		return (x2 / 4 - x1 / 4 + 1) * (y2 - y1 + 1);
	endfunction

	task automatic send(isb_pkg::req_t pkt);
		int gap;
		gap = req_burst ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= pkt;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		if (pkt.action != ACT_UNUSED) begin
			items_sent++;
		end
		if ($urandom_range(0, 39) == 0) begin
			req_burst = !req_burst;
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// result sink
	initial begin
		int stall;
		@(posedge clk);
		forever begin
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
			end else begin
				stall = rsp_burst ? 0 : $urandom_range(0, 9);
				if (stall > 0) begin
					rsp_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			if ($urandom_range(0, 39) == 0) begin
				rsp_burst = !rsp_burst;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d cycles with no item moving", idle_cycles);
			$display("tb failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		isb_pkg::req_t pkt;
		int   x1;
		int   y1;
		int   w;
		int   h;
		int   len;
		int   n;
		int   kind;
		logic pressure_done;
		logic saved_burst;

		pressure_done = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// pixel packing, colour folding and off-screen pixels
		send(mk(isb_pkg::ACT_PIXEL, 0, 0, 1, 0, 0));
		send(mk(isb_pkg::ACT_PIXEL, 1, 0, 2, 0, 0));
		send(mk(isb_pkg::ACT_PIXEL, 2, 0, 3, 0, 0));
		send(mk(isb_pkg::ACT_PIXEL, 3, 0, 15, 0, 0));
		send(mk(isb_pkg::ACT_PIXEL, 4, 0, 16, 0, 0));
		send(mk(isb_pkg::ACT_PIXEL, 5, 0, 17, 0, 0));
		send(mk(isb_pkg::ACT_PIXEL, 6, 0, 255, 0, 0));
		send(mk(isb_pkg::ACT_PIXEL, 319, 199, 3, 0, 0));
		send(mk(isb_pkg::ACT_PIXEL, 320, 0, 3, 0, 0));
		send(mk(isb_pkg::ACT_PIXEL, 0, 200, 3, 0, 0));
		send(mk(ACT_UNUSED, 511, 255, 255, 1023, 1023));
		send(mk(isb_pkg::ACT_TICK, 0, 0, 0, 0, 0));
		// clamped corner copy, odd top row rounded down
		send(mk(isb_pkg::ACT_BLOCK, 511, 255, 0, 1023, 1023));
		repeat (3) send(mk(isb_pkg::ACT_TICK, 0, 0, 0, 0, 0));
		// pixel lands mid copy before its byte is read
		send(mk(isb_pkg::ACT_BLOCK, 0, 1, 0, 7, 1));
		send(mk(isb_pkg::ACT_TICK, 0, 0, 0, 0, 0));
		send(mk(isb_pkg::ACT_PIXEL, 1, 1, 3, 0, 0));
		repeat (3) send(mk(isb_pkg::ACT_TICK, 0, 0, 0, 0, 0));
		// empty rectangles
		send(mk(isb_pkg::ACT_BLOCK, 100, 0, 0, 50, 10));
		send(mk(isb_pkg::ACT_TICK, 0, 0, 0, 0, 0));
		send(mk(isb_pkg::ACT_BLOCK, 0, 10, 0, 3, 5));
		send(mk(isb_pkg::ACT_TICK, 0, 0, 0, 0, 0));
		// even rows only, then restart
		send(mk(isb_pkg::ACT_BLOCK, 0, 4, 0, 15, 4));
		send(mk(isb_pkg::ACT_TICK, 0, 0, 0, 0, 0));
		send(mk(isb_pkg::ACT_BLOCK, 0, 0, 0, 3, 0));
		repeat (2) send(mk(isb_pkg::ACT_TICK, 0, 0, 0, 0, 0));
		drain();

		while (items_sent < ITEM_TARGET) begin
			if (!pressure_done && items_sent >= 600) begin
				// sink stalls while ticks keep coming, then the source waits for all writes
				pressure_done = 1'b1;
				saved_burst = req_burst;
				req_burst = 1'b1;
				hold_rsp = 1'b1;
				pkt = mk(isb_pkg::ACT_BLOCK, 0, 0, 0, 63, 7);
				send(pkt);
				repeat (copy_len(pkt)) send(random_fields(isb_pkg::ACT_TICK));
				req_burst = saved_burst;
				drain();
			end
			kind = $urandom_range(0, 9);
			if (kind <= 6) begin
				x1 = $urandom_range(0, 319);
				w = $urandom_range(0, 23);
				y1 = $urandom_range(0, 199);
				h = $urandom_range(0, 5);
				repeat ($urandom_range(0, 4)) send(rect_pixel(x1, w, y1, h));
				pkt = mk(isb_pkg::ACT_BLOCK, x1, y1, $urandom_range(0, 255), x1 + w, y1 + h);
				send(pkt);
				len = copy_len(pkt);
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len) :
					len + $urandom_range(0, 1);
				repeat (n) begin
					if ($urandom_range(0, 5) == 0) begin
						send(rect_pixel(x1, w, y1, h));
					end
					send(random_fields(isb_pkg::ACT_TICK));
				end
			end else if (kind == 7) begin
				send(random_fields(2'($urandom_range(0, 3))));
			end else if (kind == 8) begin
				send(random_fields(isb_pkg::ACT_BLOCK));
				repeat ($urandom_range(0, 4)) send(random_fields(isb_pkg::ACT_TICK));
			end else begin
				repeat ($urandom_range(1, 4)) send(random_fields(isb_pkg::ACT_PIXEL));
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("run covered %0d items: %0d pixel writes, %0d block copies armed",
			items_sent, pixels_drawn, copies_armed);
		$display("%0d framebuffer writes checked, %0d mismatches", writes_seen, mismatches);
		if (mismatches == 0 && pending == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
